// ----- design/stc3_pkg.sv -----
package stc3_pkg;

  localparam int unsigned FracW = 20;
  localparam int unsigned QW    = 32;
  localparam int unsigned RadW  = 31;
  localparam int unsigned RootW = 26;
  localparam int unsigned GuardW = 16;
  localparam int unsigned DivW  = 27;
  localparam int unsigned NumW  = 44;
  localparam int unsigned ProdW = 64;

  localparam logic signed [QW-1:0] QMax = {1'b0, {(QW-1){1'b1}}};
  localparam logic signed [QW-1:0] QMin = {1'b1, {(QW-1){1'b0}}};

endpackage

// ----- design/stress_tensor_cholesky_3x3.sv -----
// Computes the lower-triangular Cholesky factor of one symmetric 3x3 stress
// tensor per item, all values in Q12.20. The block accepts one item in every
// clock cycle while the output is not stalled. The path is made of three
// bit-serial square-root pipelines of 26 stages and two rows of long-division
// pipelines of 33 stages that follow one another. After each division row
// there are two product stages and one radicand stage, and one more stage
// feeds each of the later square roots.
// Input ready falls only while a finished result waits at the output, and the
// guard register may only be written while no item is in flight.
module stress_tensor_cholesky_3x3 (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [15:0]  cfg_wdata_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // r_xx, r_xy, r_xz, r_yy, r_yz, r_zz, 32 bits each.
  input  logic [191:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // l_xx 31, l_yx 32, l_yy 31, l_zx 32, l_zy 32, l_zz 31, clamp_flags 3.
  output logic [191:0] m_axis_tdata
);

  localparam int unsigned QW    = stc3_pkg::QW;
  localparam int unsigned RadW  = stc3_pkg::RadW;
  localparam int unsigned RootW = stc3_pkg::RootW;
  localparam int unsigned NumW  = stc3_pkg::NumW;
  localparam int unsigned ProdW = stc3_pkg::ProdW;
  localparam int unsigned FracW = stc3_pkg::FracW;

  localparam int unsigned XxOut = RootW;
  localparam int unsigned DivIn1 = XxOut;
  localparam int unsigned DivOut1 = DivIn1 + QW + 1;
  localparam int unsigned MulSt1 = DivOut1 + 2;
  localparam int unsigned RadSt1 = MulSt1 + 1;
  localparam int unsigned YyIn  = RadSt1 + 1;
  localparam int unsigned YyOut = YyIn + RootW;
  localparam int unsigned DivOut2 = YyOut + QW + 1;
  localparam int unsigned MulSt2 = DivOut2 + 2;
  localparam int unsigned RadSt2 = MulSt2 + 1;
  localparam int unsigned ZzIn  = RadSt2 + 1;
  localparam int unsigned Last  = ZzIn + RootW;

  typedef struct packed {
    logic signed [QW-1:0]    rxx;
    logic signed [QW-1:0]    rxy;
    logic signed [QW-1:0]    rxz;
    logic signed [QW-1:0]    ryy;
    logic signed [QW-1:0]    ryz;
    logic signed [QW-1:0]    rzz;
    logic [2:0]              flags;
    logic [RootW-1:0]        lxx;
    logic [RootW-1:0]        lyy;
    logic signed [QW-1:0]    lyx;
    logic signed [QW-1:0]    lzx;
    logic signed [QW-1:0]    lzy;
    logic signed [ProdW-1:0] p1;
    logic signed [ProdW-1:0] p2;
    logic signed [ProdW-1:0] p3;
    logic signed [ProdW-1:0] p4;
    logic [RadW-1:0]         rad_y;
    logic [RadW-1:0]         rad_z;
    logic signed [NumW-1:0]  num_zy;
  } side_t;

  logic [15:0]          guard_q;
  logic                 vld_q  [Last+1];
  side_t                side_q [Last+1];
  side_t                side_d [Last+1];
  logic                 en;
  logic [RootW-1:0]     lxx_w;
  logic [RootW-1:0]     lyy_w;
  logic [RootW-1:0]     lzz_w;
  logic signed [QW-1:0] lyx_w;
  logic signed [QW-1:0] lzx_w;
  logic signed [QW-1:0] lzy_w;
  logic [RadW-1:0]      rad_x;
  logic signed [ProdW-1:0] diff_y;
  logic signed [ProdW-1:0] diff_zy;
  logic signed [ProdW-1:0] diff_z;

  assign en            = !vld_q[Last] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[Last];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      guard_q <= 16'd1;
    end else if (cfg_we_i) begin
      guard_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= Last; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else if (en) begin
      vld_q[0] <= s_axis_tvalid;
      for (int k = 1; k <= Last; k++) begin
        vld_q[k] <= vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k <= Last; k++) begin
        side_q[k] <= side_d[k];
      end
    end
  end

  assign rad_x = side_q[0].rxx[QW-1] ? '0 : side_q[0].rxx[RadW-1:0];

  assign diff_y  = ProdW'(side_q[RadSt1-1].ryy) - (side_q[RadSt1-1].p1 >>> FracW);
  assign diff_zy = ProdW'(side_q[RadSt1-1].ryz) - (side_q[RadSt1-1].p2 >>> FracW);
  assign diff_z  = ProdW'(side_q[RadSt2-1].rzz) - (side_q[RadSt2-1].p3 >>> FracW)
                   - (side_q[RadSt2-1].p4 >>> FracW);

  always_comb begin
    side_d[0]        = '0;
    side_d[0].rxx    = s_axis_tdata[31:0];
    side_d[0].rxy    = s_axis_tdata[63:32];
    side_d[0].rxz    = s_axis_tdata[95:64];
    side_d[0].ryy    = s_axis_tdata[127:96];
    side_d[0].ryz    = s_axis_tdata[159:128];
    side_d[0].rzz    = s_axis_tdata[191:160];
    side_d[0].flags  = {2'b00, s_axis_tdata[31]};
    for (int k = 1; k <= Last; k++) begin
      side_d[k] = side_q[k-1];
    end
    side_d[XxOut+1].lxx   = lxx_w;
    side_d[DivOut1+1].lyx = lyx_w;
    side_d[DivOut1+1].lzx = lzx_w;
    side_d[MulSt1].p1     = side_q[MulSt1-1].lyx * side_q[MulSt1-1].lyx;
    side_d[MulSt1].p2     = side_q[MulSt1-1].lyx * side_q[MulSt1-1].lzx;
    side_d[MulSt1].p3     = side_q[MulSt1-1].lzx * side_q[MulSt1-1].lzx;
    side_d[RadSt1].flags[1] = diff_y[ProdW-1];
    side_d[RadSt1].rad_y  = diff_y[ProdW-1] ? '0 : diff_y[RadW-1:0];
    side_d[RadSt1].num_zy = diff_zy[NumW-1:0];
    side_d[YyOut+1].lyy   = lyy_w;
    side_d[DivOut2+1].lzy = lzy_w;
    side_d[MulSt2].p4     = side_q[MulSt2-1].lzy * side_q[MulSt2-1].lzy;
    side_d[RadSt2].flags[2] = diff_z[ProdW-1];
    side_d[RadSt2].rad_z  = diff_z[ProdW-1] ? '0 : diff_z[RadW-1:0];
  end

  stc3_sqrt u_sqrt_xx (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (rad_x),
    .root_o (lxx_w)
  );

  stc3_div u_div_yx (
    .clk_i   (clk_i),
    .en_i    (en),
    .num_i   (NumW'(side_q[DivIn1].rxy)),
    .guard_i (guard_q),
    .diag_i  (lxx_w),
    .quo_o   (lyx_w)
  );

  stc3_div u_div_zx (
    .clk_i   (clk_i),
    .en_i    (en),
    .num_i   (NumW'(side_q[DivIn1].rxz)),
    .guard_i (guard_q),
    .diag_i  (lxx_w),
    .quo_o   (lzx_w)
  );

  stc3_sqrt u_sqrt_yy (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (side_q[YyIn].rad_y),
    .root_o (lyy_w)
  );

  stc3_div u_div_zy (
    .clk_i   (clk_i),
    .en_i    (en),
    .num_i   (side_q[YyOut].num_zy),
    .guard_i (guard_q),
    .diag_i  (lyy_w),
    .quo_o   (lzy_w)
  );

  stc3_sqrt u_sqrt_zz (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (side_q[ZzIn].rad_z),
    .root_o (lzz_w)
  );

  assign m_axis_tdata = {
    side_q[Last].flags,
    RadW'(lzz_w),
    side_q[Last].lzy,
    side_q[Last].lzx,
    RadW'(side_q[Last].lyy),
    side_q[Last].lyx,
    RadW'(side_q[Last].lxx)
  };

endmodule

// ----- design/stc3_sqrt.sv -----
module stc3_sqrt (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  logic [stc3_pkg::RadW-1:0]       rad_i,
  output logic [stc3_pkg::RootW-1:0]      root_o
);

  localparam int unsigned RootW = stc3_pkg::RootW;
  localparam int unsigned NW    = 2 * RootW;
  localparam int unsigned RemW  = RootW + 2;

  logic [RemW-1:0]  rem_q  [RootW];
  logic [RootW-1:0] root_q [RootW];
  logic [NW-1:0]    n_q    [RootW];
  logic [NW-1:0]    n_in;

  assign n_in = NW'({rad_i, {stc3_pkg::FracW{1'b0}}});

  for (genvar k = 0; k < RootW; k++) begin : g_step
    logic [RemW-1:0]  rem_in;
    logic [RootW-1:0] root_in;
    logic [NW-1:0]    n_cur;
    logic [RemW+1:0]  rem_t;
    logic [RemW+1:0]  trial;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign n_cur   = n_in;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign n_cur   = n_q[k-1];
    end

    assign rem_t = {rem_in, n_cur[NW-1-2*k -: 2]};
    assign trial = (RemW+2)'({root_in, 2'b01});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (rem_t >= trial) begin
          rem_q[k]  <= RemW'(rem_t - trial);
          root_q[k] <= {root_in[RootW-2:0], 1'b1};
        end else begin
          rem_q[k]  <= RemW'(rem_t);
          root_q[k] <= {root_in[RootW-2:0], 1'b0};
        end
        n_q[k] <= n_cur;
      end
    end
  end

  assign root_o = root_q[RootW-1];

endmodule

// ----- design/stc3_div.sv -----
module stc3_div (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic signed [stc3_pkg::NumW-1:0]  num_i,
  input  logic [stc3_pkg::GuardW-1:0]       guard_i,
  input  logic [stc3_pkg::RootW-1:0]        diag_i,
  output logic signed [stc3_pkg::QW-1:0]    quo_o
);

  localparam int unsigned DivW  = stc3_pkg::DivW;
  localparam int unsigned NumW  = stc3_pkg::NumW;
  localparam int unsigned QW    = stc3_pkg::QW;
  localparam int unsigned MW    = NumW + stc3_pkg::FracW;
  localparam int unsigned Steps = QW - 1;

  logic [NumW-1:0] mag;
  logic [MW-1:0]   m0_q;
  logic [DivW-1:0] d0_q;
  logic            neg0_q;
  logic            zero0_q;

  logic [DivW-1:0]  r_q    [Steps+1];
  logic [DivW-1:0]  d_q    [Steps+1];
  logic [Steps-1:0] mlo_q  [Steps+1];
  logic [Steps-1:0] q_q    [Steps+1];
  logic             sat_q  [Steps+1];
  logic             neg_q  [Steps+1];
  logic             zero_q [Steps+1];

  assign mag = num_i[NumW-1] ? NumW'(-num_i) : NumW'(num_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d0_q    <= DivW'(guard_i) + DivW'(diag_i);
      m0_q    <= {mag, {stc3_pkg::FracW{1'b0}}};
      neg0_q  <= num_i[NumW-1];
      zero0_q <= (num_i == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sat_q[0]  <= (m0_q >= MW'({d0_q, {Steps{1'b0}}}));
      r_q[0]    <= m0_q[Steps +: DivW];
      mlo_q[0]  <= m0_q[Steps-1:0];
      d_q[0]    <= d0_q;
      q_q[0]    <= '0;
      neg_q[0]  <= neg0_q;
      zero_q[0] <= zero0_q;
    end
  end

  for (genvar j = 0; j < Steps; j++) begin : g_step
    logic [DivW:0] t;
    logic          ge;

    assign t  = {r_q[j], mlo_q[j][Steps-1-j]};
    assign ge = (t >= {1'b0, d_q[j]});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[j+1]    <= ge ? DivW'(t - {1'b0, d_q[j]}) : DivW'(t);
        q_q[j+1]    <= {q_q[j][Steps-2:0], ge};
        mlo_q[j+1]  <= mlo_q[j];
        d_q[j+1]    <= d_q[j];
        sat_q[j+1]  <= sat_q[j];
        neg_q[j+1]  <= neg_q[j];
        zero_q[j+1] <= zero_q[j];
      end
    end
  end

  always_comb begin
    if (zero_q[Steps]) begin
      quo_o = '0;
    end else if (sat_q[Steps]) begin
      quo_o = neg_q[Steps] ? stc3_pkg::QMin : stc3_pkg::QMax;
    end else if (neg_q[Steps]) begin
      quo_o = -$signed({1'b0, q_q[Steps]});
    end else begin
      quo_o = $signed({1'b0, q_q[Steps]});
    end
  end

endmodule

// ----- design/stc3_checker.sv -----
module stc3_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [191:0] m_axis_tdata
);

  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("Output item changed while stalled.");

  a_stall_blocks_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("Input accepted while the pipeline is stalled.");

  a_ready_when_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("Input refused with an empty output stage.");

  a_root_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[30:26] == 5'd0 && m_axis_tdata[93:89] == 5'd0
                      && m_axis_tdata[188:184] == 5'd0)
    else $error("Diagonal entry exceeds the square-root range.");

  a_clamp_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[189] |-> m_axis_tdata[30:0] == 31'd0)
    else $error("Clamped diagonal entry is not zero.");

endmodule

bind stress_tensor_cholesky_3x3 stc3_checker u_stc3_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
